/* rtl/core/sbd_pkg.sv */
// Shared types, widths and constants for the sponge boundary damping block.
// Used by sbd_axis_classify and sponge_boundary_damping; depends on nothing.

package sbd_pkg;

    // Table and grid limits.
    localparam int MAX_BOUNDARY   = 32;
    localparam int MAX_GRID       = 1024;
    localparam int COEF_FRAC_BITS = 16;

    // Field widths.
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int HALO_W    = 5;
    localparam int BW_W      = 6;
    localparam int SAMPLE_W  = 32;
    localparam int COEF_W    = 17;
    localparam int ADDR_W    = $clog2(MAX_BOUNDARY);
    localparam int PROD_W    = SAMPLE_W + COEF_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_HALO_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_DIM      = 3'd5;

    // Input kind codes.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // A coefficient of exactly 1.0.
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);

    // Classification of one sample position along one axis.
    typedef struct packed {
        logic              outside;  // in the halo or beyond the axis size
        logic              strip;    // inside the damping strip
        logic [ADDR_W-1:0] addr;     // strip distance, table address
    } axis_info_t;

endpackage

/* rtl/core/sbd_axis_classify.sv */
// Per-axis classification of a sample position: halo, strip or interior.
// Depends on sbd_pkg for widths, limits and the axis_info_t struct.

module sbd_axis_classify
    import sbd_pkg::*;
(
    input  logic [POS_W-1:0]  pos,
    input  logic [SIZE_W-1:0] size,
    input  logic [HALO_W-1:0] halo,
    input  logic [BW_W-1:0]   bw,
    output axis_info_t        info
);

    logic [SIZE_W-1:0] size_c;
    logic [BW_W-1:0]   bw_c;
    logic [SIZE_W-1:0] pos_ext;
    logic [SIZE_W-1:0] halo_ext;
    logic [SIZE_W-1:0] lo_dist;
    logic [SIZE_W-1:0] hi_dist;
    logic [SIZE_W-1:0] near_dist;

    // Clamp the axis size and the strip width to what the hardware supports.
    assign size_c   = (size > SIZE_W'(MAX_GRID)) ? SIZE_W'(MAX_GRID) : size;
    assign bw_c     = (bw > BW_W'(MAX_BOUNDARY)) ? BW_W'(MAX_BOUNDARY) : bw;
    assign pos_ext  = SIZE_W'(pos);
    assign halo_ext = SIZE_W'(halo);

    // Distance to the lower and upper domain edges; the nearer one counts.
    assign lo_dist   = pos_ext - halo_ext;
    assign hi_dist   = size_c - halo_ext - SIZE_W'(1) - pos_ext;
    assign near_dist = (lo_dist < hi_dist) ? lo_dist : hi_dist;

    // The sum cannot overflow: pos and halo together stay below 2048.
    assign info.outside = (pos_ext < halo_ext) || ((pos_ext + halo_ext) >= size_c);
    assign info.strip   = !info.outside && (near_dist < SIZE_W'(bw_c));
    assign info.addr    = near_dist[ADDR_W-1:0];

endmodule

/* rtl/core/sponge_boundary_damping.sv */
// Top level of the sponge boundary damping block: coefficient tables,
// three-stage sample pipeline and configuration registers.
// Depends on sbd_pkg and sbd_axis_classify.
//
// Usage:
//   Input channel (in_valid/in_ready): each transaction is either a load
//   (kind 0), which writes coef_value, clamped to 1.0, into table slot
//   coef_index and gives no result, or a sample (kind 1), which gives one
//   result on the output channel (out_valid/out_ready).
//   Configuration channel (cfg_valid/cfg_ready): always ready; writes the
//   register named by cfg_index; indexes beyond the list are ignored.
//   Write configuration only while no sample is in flight.
//   Throughput: one transaction per cycle while out_ready does not stall
//   the pipeline, set by the two coefficient memories, which give three
//   reads (x, y, z) every cycle.
//   A sample may follow a load of the slot it reads in the very next cycle.
//   Stall: while out_ready is low the result holds; the two internal
//   stages still fill, so up to two more samples are accepted before
//   in_ready drops.
//   Reset: configuration returns to its defaults and the pipeline empties.
//   The coefficient tables are not cleared and must be loaded before use.

module sponge_boundary_damping
    import sbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [POS_W-1:0]       pos_x,
    input  logic [POS_W-1:0]       pos_y,
    input  logic [POS_W-1:0]       pos_z,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [ADDR_W-1:0]      coef_index,
    input  logic [COEF_W-1:0]      coef_value,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [SAMPLE_W-1:0] damped_value,
    output logic                   was_scaled
);

    // Configuration registers.
    logic [HALO_W-1:0] halo_width_reg;
    logic [BW_W-1:0]   boundary_width_reg;
    logic [SIZE_W-1:0] size_x_reg;
    logic [SIZE_W-1:0] size_y_reg;
    logic [SIZE_W-1:0] size_z_reg;
    logic              three_dim_reg;

    // Coefficient memories; both hold the same contents.
    logic [COEF_W-1:0] mem_a [MAX_BOUNDARY];
    logic [COEF_W-1:0] mem_b [MAX_BOUNDARY];
    logic [COEF_W-1:0] rd_x_reg;
    logic [COEF_W-1:0] rd_z_reg;
    logic [COEF_W-1:0] rd_y_reg;

    // Pipeline stage enables.
    logic en1;
    logic en2;
    logic en3;

    logic              in_accept;
    logic              coef_wr;
    logic [COEF_W-1:0] coef_wr_data;

    axis_info_t info_x;
    axis_info_t info_y_raw;
    axis_info_t info_y;
    axis_info_t info_z;

    // Stage 1: classification; coefficient reads are in flight.
    logic                       v1_reg;
    logic                       v1_next;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    axis_info_t                 s1_x_reg;
    axis_info_t                 s1_y_reg;
    axis_info_t                 s1_z_reg;

    logic [COEF_W-1:0] cand_x;
    logic [COEF_W-1:0] cand_y;
    logic [COEF_W-1:0] cand_z;
    logic [COEF_W-1:0] min_xz;
    logic [COEF_W-1:0] min_all;
    logic              s1_scaled;

    // Stage 2: selected coefficient, ready for the multiply.
    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic [COEF_W-1:0]          s2_coef_reg;
    logic                       s2_scaled_reg;

    logic signed [PROD_W-1:0] prod;

    // Output register.
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] damped_reg;
    logic                       scaled_reg;

    // Stages move forward when the next one is empty or moving too.
    assign en3      = !out_valid_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign cfg_ready = 1'b1;

    assign in_accept = in_valid && in_ready;
    assign coef_wr   = in_accept && (kind == KIND_LOAD);
    assign coef_wr_data = (coef_value > COEF_ONE) ? COEF_ONE : coef_value;
    assign v1_next   = in_accept && (kind == KIND_SAMPLE);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halo_width_reg     <= HALO_W'(4);
            boundary_width_reg <= BW_W'(20);
            size_x_reg         <= SIZE_W'(1024);
            size_y_reg         <= SIZE_W'(1);
            size_z_reg         <= SIZE_W'(1024);
            three_dim_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALO_WIDTH:     halo_width_reg     <= cfg_data[HALO_W-1:0];
                CFG_BOUNDARY_WIDTH: boundary_width_reg <= cfg_data[BW_W-1:0];
                CFG_SIZE_X:         size_x_reg         <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:         size_y_reg         <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:         size_z_reg         <= cfg_data[SIZE_W-1:0];
                CFG_THREE_DIM:      three_dim_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Axis classification of the incoming position.
    sbd_axis_classify u_axis_x
    (
        .pos  (pos_x),
        .size (size_x_reg),
        .halo (halo_width_reg),
        .bw   (boundary_width_reg),
        .info (info_x)
    );

    sbd_axis_classify u_axis_y
    (
        .pos  (pos_y),
        .size (size_y_reg),
        .halo (halo_width_reg),
        .bw   (boundary_width_reg),
        .info (info_y_raw)
    );

    sbd_axis_classify u_axis_z
    (
        .pos  (pos_z),
        .size (size_z_reg),
        .halo (halo_width_reg),
        .bw   (boundary_width_reg),
        .info (info_z)
    );

    // In 2-D mode the y axis neither damps nor excludes a point.
    assign info_y = three_dim_reg ? info_y_raw : '0;

    // Memory A serves x and z. A load writes at the accept edge, so a sample
    // accepted in the next cycle already reads the new value.
    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            mem_a[coef_index] <= coef_wr_data;
        end
        if (en1)
        begin
            rd_x_reg <= mem_a[info_x.addr];
            rd_z_reg <= mem_a[info_z.addr];
        end
    end

    // Memory B serves y.
    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            mem_b[coef_index] <= coef_wr_data;
        end
        if (en1)
        begin
            rd_y_reg <= mem_b[info_y.addr];
        end
    end

    // Stage 1 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sample_reg <= sample_value;
            s1_x_reg      <= info_x;
            s1_y_reg      <= info_y;
            s1_z_reg      <= info_z;
        end
    end

    // Smallest coefficient over the strips that the point lies in.
    assign cand_x  = s1_x_reg.strip ? rd_x_reg : COEF_ONE;
    assign cand_y  = s1_y_reg.strip ? rd_y_reg : COEF_ONE;
    assign cand_z  = s1_z_reg.strip ? rd_z_reg : COEF_ONE;
    assign min_xz  = (cand_x < cand_z) ? cand_x : cand_z;
    assign min_all = (cand_y < min_xz) ? cand_y : min_xz;

    assign s1_scaled = !(s1_x_reg.outside || s1_y_reg.outside || s1_z_reg.outside)
                       && (s1_x_reg.strip || s1_y_reg.strip || s1_z_reg.strip);

    // Stage 2 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_coef_reg   <= min_all;
            s2_scaled_reg <= s1_scaled;
        end
    end

    // Signed sample times unsigned coefficient.
    assign prod = s2_sample_reg * $signed({1'b0, s2_coef_reg});

    // Output register: scaled product shifted right, or the sample itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            damped_reg <= s2_scaled_reg ? prod[COEF_FRAC_BITS+SAMPLE_W-1:COEF_FRAC_BITS]
                                        : s2_sample_reg;
            scaled_reg <= s2_scaled_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign damped_value = damped_reg;
    assign was_scaled   = scaled_reg;

    // A load transaction never puts an item into the pipeline.
    a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_LOAD)) |=> !v1_reg)
        else $error("load transaction entered the sample pipeline");

    // An unscaled sample leaves exactly as it came in.
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && !s2_scaled_reg)
        |=> (out_valid && !was_scaled && (damped_value == $past(s2_sample_reg))))
        else $error("unscaled sample was altered");

    // Scaling by a coefficient of at most one keeps a non-negative sample so.
    a_scaled_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && s2_scaled_reg && !s2_sample_reg[SAMPLE_W-1])
        |=> (out_valid && was_scaled && !damped_value[SAMPLE_W-1]))
        else $error("scaled result changed sign");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for sponge_boundary_damping: random and directed
// load and sample transactions, checked against a scoreboard that predicts
// each damped result. Depends on sbd_pkg and the sponge_boundary_damping RTL.

module tb_top;
    import sbd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 10;

    // Axis classification codes used by the predictor.
    localparam int AXIS_OUTSIDE  = -2;
    localparam int AXIS_INTERIOR = -1;

    // A register index past the end of the list; the block ignores it.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd7;

    typedef struct packed {
        logic                kind;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
        logic [POS_W-1:0]    pz;
        logic [SAMPLE_W-1:0] value;
        logic [ADDR_W-1:0]   slot;
        logic [COEF_W-1:0]   coef;
    } damping_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                scaled;
    } damped_result_t;

    // Predicts the damped value of each sample and holds the results still owed.
    class damping_scoreboard;
        int halo_width;
        int boundary_width;
        int size_x;
        int size_y;
        int size_z;
        int three_dim;
        logic [COEF_W-1:0] coef_table [MAX_BOUNDARY];
        damped_result_t expected_damped [$];
        int errors;

        function new();
            halo_width     = 4;
            boundary_width = 20;
            size_x         = 1024;
            size_y         = 1;
            size_z         = 1024;
            three_dim      = 0;
            errors         = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HALO_WIDTH:     halo_width     = int'(data[HALO_W-1:0]);
                CFG_BOUNDARY_WIDTH: boundary_width = int'(data[BW_W-1:0]);
                CFG_SIZE_X:         size_x         = int'(data[SIZE_W-1:0]);
                CFG_SIZE_Y:         size_y         = int'(data[SIZE_W-1:0]);
                CFG_SIZE_Z:         size_z         = int'(data[SIZE_W-1:0]);
                CFG_THREE_DIM:      three_dim      = int'(data[0]);
                default:            ;
            endcase
        endfunction

        // Distance into the strip from the nearer edge, or a classification code.
        function int strip_dist(int p, int n);
            int w;
            int lo;
            int hi;
            int dd;
            w = (boundary_width > MAX_BOUNDARY) ? MAX_BOUNDARY : boundary_width;
            if (n > MAX_GRID)
                n = MAX_GRID;
            if (p < halo_width || p + halo_width >= n)
                return AXIS_OUTSIDE;
            lo = p - halo_width;
            hi = n - halo_width - 1 - p;
            dd = (lo < hi) ? lo : hi;
            return (dd < w) ? dd : AXIS_INTERIOR;
        endfunction

        function damped_result_t predict(damping_item_t it);
            int d [3];
            int naxes;
            int k;
            bit in_halo;
            bit in_strip;
            logic [COEF_W-1:0] coef;
            longint prod;
            damped_result_t r;
            in_halo  = 1'b0;
            in_strip = 1'b0;
            coef     = COEF_ONE;
            d[0]  = strip_dist(int'(it.px), size_x);
            d[1]  = strip_dist(int'(it.pz), size_z);
            naxes = 2;
            if (three_dim != 0) begin
                d[2]  = strip_dist(int'(it.py), size_y);
                naxes = 3;
            end
            for (k = 0; k < naxes; k++) begin
                if (d[k] == AXIS_OUTSIDE) begin
                    in_halo = 1'b1;
                end
                else if (d[k] >= 0) begin
                    in_strip = 1'b1;
                    if (coef_table[d[k]] < coef)
                        coef = coef_table[d[k]];
                end
            end
            if (in_halo || !in_strip) begin
                r.value  = it.value;
                r.scaled = 1'b0;
            end
            else begin
                prod     = longint'($signed(it.value)) * longint'(coef);
                r.value  = SAMPLE_W'(prod >>> COEF_FRAC_BITS);
                r.scaled = 1'b1;
            end
            return r;
        endfunction

        // Loads update the table; samples queue a prediction.
        function void note_input(damping_item_t it);
            if (it.kind == KIND_LOAD)
                coef_table[it.slot] = (it.coef > COEF_ONE) ? COEF_ONE : it.coef;
            else
                expected_damped.push_back(predict(it));
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] value, logic scaled);
            damped_result_t exp_r;
            if (expected_damped.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: damped_value %0d, was_scaled %0d",
                         $time, $signed(value), scaled);
                return;
            end
            exp_r = expected_damped.pop_front();
            if (value !== exp_r.value) begin
                errors++;
                $display("%0t: damped_value mismatch: expected %0d, actual %0d",
                         $time, $signed(exp_r.value), $signed(value));
            end
            if (scaled !== exp_r.scaled) begin
                errors++;
                $display("%0t: was_scaled mismatch: expected %0d, actual %0d",
                         $time, exp_r.scaled, scaled);
            end
        endfunction

        function int pending();
            return expected_damped.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  kind;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [POS_W-1:0]      pos_z;
    logic [SAMPLE_W-1:0]   sample_value;
    logic [ADDR_W-1:0]     coef_index;
    logic [COEF_W-1:0]     coef_value;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  out_valid;
    logic                  out_ready;
    logic [SAMPLE_W-1:0]   damped_value;
    logic                  was_scaled;

    damping_scoreboard damp_sb = new();
    bit sender_no_gaps;
    int idle_cycles = 0;
    int phase_items [NUM_PHASES] = '{250, 200, 200, 150, 150, 60, 240, 240, 220, 220};

    sponge_boundary_damping dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .sample_value (sample_value),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .damped_value (damped_value),
        .was_scaled   (was_scaled)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Position biased toward strips, halos and the far edge of an axis.
    function logic [POS_W-1:0] pick_pos(int n, int h, int w);
        int v;
        int r;
        if (n > MAX_GRID)
            n = MAX_GRID;
        if (w > MAX_BOUNDARY)
            w = MAX_BOUNDARY;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    v = $urandom_range(0, 1023);
            2, 3, 4: v = h + $urandom_range(0, w + 1);
            5, 6, 7: v = n - h - 1 - $urandom_range(0, w + 1);
            8:       v = $urandom_range(0, h);
            default: v = n - h + $urandom_range(0, 1);
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return POS_W'(v);
    endfunction

    function damping_item_t sample_at(int x, int y, int z, logic [SAMPLE_W-1:0] v);
        damping_item_t it;
        it       = '0;
        it.kind  = KIND_SAMPLE;
        it.px    = POS_W'(x);
        it.py    = POS_W'(y);
        it.pz    = POS_W'(z);
        it.value = v;
        it.slot  = ADDR_W'($urandom);
        it.coef  = COEF_W'($urandom);
        return it;
    endfunction

    function damping_item_t load_slot(int slot, int c);
        damping_item_t it;
        it      = '0;
        it.kind = KIND_LOAD;
        it.px   = POS_W'($urandom);
        it.py   = POS_W'($urandom);
        it.pz   = POS_W'($urandom);
        it.value = $urandom;
        it.slot = ADDR_W'(slot);
        it.coef = COEF_W'(c);
        return it;
    endfunction

    function damping_item_t random_item();
        int r;
        logic [SAMPLE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       return load_slot($urandom_range(0, 31), 0);
                1:       return load_slot($urandom_range(0, 31), COEF_ONE);
                2:       return load_slot($urandom_range(0, 31), $urandom_range(65537, 131071));
                default: return load_slot($urandom_range(0, 31), $urandom_range(0, 65536));
            endcase
        end
        r = $urandom_range(0, 15);
        case (r)
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom;
        endcase
        return sample_at(
            pick_pos(damp_sb.size_x, damp_sb.halo_width, damp_sb.boundary_width),
            pick_pos(damp_sb.size_y, damp_sb.halo_width, damp_sb.boundary_width),
            pick_pos(damp_sb.size_z, damp_sb.halo_width, damp_sb.boundary_width), v);
    endfunction

    function int rand_size();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 2047);
        return $urandom_range(8, 120);
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send_item(damping_item_t it);
        int gap;
        kind         <= it.kind;
        pos_x        <= it.px;
        pos_y        <= it.py;
        pos_z        <= it.pz;
        sample_value <= it.value;
        coef_index   <= it.slot;
        coef_value   <= it.coef;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        damp_sb.note_input(it);
        gap = sender_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        damp_sb.set_reg(idx, CFG_DATA_W'(data));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int h, int bw, int sx, int sy, int sz, int td);
        write_reg(CFG_HALO_WIDTH, h);
        write_reg(CFG_BOUNDARY_WIDTH, bw);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        write_reg(CFG_THREE_DIM, td);
    endtask

    // Stop sending, wait for every owed result, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (damp_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            damp_sb.check_result(damped_value, was_scaled);
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls mixed with stretches of steady acceptance.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int p;
        int n;
        sender_no_gaps = 1'b0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        kind           <= KIND_LOAD;
        pos_x          <= '0;
        pos_y          <= '0;
        pos_z          <= '0;
        sample_value   <= '0;
        coef_index     <= '0;
        coef_value     <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small 16-cell grid: domain 2..13 on each axis, strips four cells deep.
        set_config(2, 4, 16, 16, 16, 1);
        write_reg(CFG_NO_REGISTER, $urandom_range(0, 2047));

        // Every slot is loaded before any sample can read it.
        for (n = 0; n < MAX_BOUNDARY; n++) begin
            if (n == 0)
                send_item(load_slot(n, 17'h1FFFF));
            else if (n == 1)
                send_item(load_slot(n, 0));
            else
                send_item(load_slot(n, 65536 - n * 1500));
        end

        // Interior, halo and beyond-size points pass through.
        send_item(sample_at(8, 8, 8, 32'h7FFF_FFFF));
        send_item(sample_at(0, 8, 8, 32'h0000_1234));
        send_item(sample_at(20, 8, 8, 32'h8000_0000));
        send_item(sample_at(8, 8, 15, 32'hFFFF_FFFF));
        send_item(sample_at(1023, 1023, 1023, 32'h5555_AAAA));
        // Single strips, with a coefficient clamped to one and a zero one.
        send_item(sample_at(2, 8, 8, 32'h8000_0000));
        send_item(sample_at(3, 8, 8, 32'd12345));
        send_item(sample_at(4, 8, 8, 32'hFFFF_FFFF));
        send_item(sample_at(4, 8, 8, 32'hFFFF_FFFD));
        send_item(sample_at(8, 13, 8, 32'h7FFF_FFFF));
        // Two- and three-strip corners take the smallest coefficient.
        send_item(sample_at(5, 8, 11, 32'hFFFF_FFFD));
        send_item(sample_at(13, 2, 5, 32'h7FFF_FFFF));
        // A strip on one axis and the halo on another.
        send_item(sample_at(3, 0, 8, 32'h0BAD_CAFE));
        // A sample reading a slot loaded in the transaction just before.
        send_item(load_slot(3, 100));
        send_item(sample_at(5, 8, 8, 32'h7FFF_FFFF));
        send_item(load_slot(2, 17'h1FFFF));
        send_item(sample_at(4, 8, 8, 32'h1234_5678));

        // Two-dimensional mode: y is ignored even in its halo.
        settle();
        write_reg(CFG_THREE_DIM, 0);
        send_item(sample_at(2, 0, 8, 32'h8765_4321));
        send_item(sample_at(8, 1023, 2, 32'h7FFF_FFFF));

        // Random phases, each under its own configuration.
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0:       set_config(4, 20, 1024, 1, 1024, 0);
                1:       set_config(0, 1, 8, 8, 8, 1);
                2:       set_config(16, 32, 1024, 1024, 1024, 1);
                3:       set_config(31, 63, 2047, 2047, 2047, 1);
                4:       set_config(3, 0, 64, 64, 64, 1);
                5:       set_config(8, 40, 16, 17, 3, 1);
                default: set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                                : $urandom_range(0, 6),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                : $urandom_range(1, 12),
                                    rand_size(), rand_size(), rand_size(),
                                    $urandom_range(0, 1));
            endcase
            sender_no_gaps = (p == 2 || p == 8);
            for (n = 0; n < phase_items[p]; n++)
                send_item(random_item());
        end

        settle();
        if (damp_sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, damp_sb.pending());
        if (damp_sb.errors == 0 && damp_sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
